// File: sv/rational_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, sequencer states and shared-unit commands.
// ----------------------------------------------------------------------------
package rau_pkg;
	localparam int WORD_WIDTH_DEF = 64;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_CMP  = 3'd4;
	localparam logic [2:0] OP_SQRT = 3'd5;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M1,
		ST_M1W,
		ST_M2,
		ST_M2W,
		ST_M3,
		ST_M3W,
		ST_COMB,
		ST_NORM,
		ST_GCD,
		ST_GCDW,
		ST_DN,
		ST_DNW,
		ST_DD,
		ST_DDW,
		ST_SQ1,
		ST_SQ1W,
		ST_SQ2,
		ST_SQ2W,
		ST_OUT
	} state_t;
endpackage

// File: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide, compare and square root on sign-magnitude
// fractions with wrapping products and GCD normalization.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Each multiply and divide runs on one shared
// bit-serial unit at one bit per cycle. An add costs three products, plus a
// Euclid loop of one divide per remainder step and two divides by the GCD. A
// divide by zero, a compare of mixed signs or an unknown operation skips the
// shared unit and goes straight to the result.
module rational_arithmetic_unit #(
	parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[2:0], x_neg, x_num[63:0], x_den[63:0], y_neg, y_num, y_den, pad
	input  logic [263:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// res_neg, res_num[63:0], res_den[63:0], order[1:0], error, pad
	output logic [135:0] m_tdata
);
	`include "rational_arithmetic_unit_macros.svh"

	logic [WORD_WIDTH-1:0] r_num, r_den;
	logic                  r_neg, r_err, busy;
	logic [1:0]            r_ord;

	rau_ctrl #(.WORD_WIDTH(WORD_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tdata[2:0]), .xn(s_tdata[3]),
		.xu(s_tdata[4 +: WORD_WIDTH]), .xd(s_tdata[68 +: WORD_WIDTH]),
		.yn(s_tdata[132]),
		.yu(s_tdata[133 +: WORD_WIDTH]), .yd(s_tdata[197 +: WORD_WIDTH]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.r_neg(r_neg), .r_num(r_num), .r_den(r_den), .r_ord(r_ord), .r_err(r_err),
		.busy(busy)
	);

	assign m_tdata = {4'b0000, r_err, r_ord, 64'(r_den), 64'(r_num), r_neg};

	`RAU_ASSERT_IMP(a_ready_idle, clk, arst_n, s_tready, !m_tvalid)
	`RAU_ASSERT_NXT(a_busy_after, clk, arst_n, s_tvalid && s_tready, busy)
	`RAU_ASSERT_IMP(a_ord_valid, clk, arst_n, m_tvalid, m_tdata[130:129] != 2'b10)
endmodule

// File: sv/rau_alu.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit shared iterative unit
// Bit-serial multiply (wrapping), restoring divide (remainder and quotient)
// and digit-by-digit floor square root, one step per cycle.
// ----------------------------------------------------------------------------
module rau_alu #(
	parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  rau_pkg::alu_cmd_t     cmd,
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] res,
	output logic [WORD_WIDTH-1:0] rem
);
	localparam int CW = $clog2(WORD_WIDTH + 1);

	logic                  busy_q;
	rau_pkg::alu_cmd_t     cmd_q;
	logic [CW-1:0]         cnt_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] opa_q;
	logic [WORD_WIDTH-1:0] opb_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [WORD_WIDTH:0]   trial;
	logic [WORD_WIDTH+1:0] sq_rem;
	logic [WORD_WIDTH+1:0] sq_try;

	always_comb begin
		trial  = {rem_q, opa_q[WORD_WIDTH-1]};
		sq_rem = {rem_q, opa_q[WORD_WIDTH-1:WORD_WIDTH-2]};
		sq_try = {acc_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cmd_q  <= cmd;
				opa_q  <= a;
				opb_q  <= b;
				acc_q  <= '0;
				rem_q  <= '0;
				cnt_q  <= (cmd == rau_pkg::ALU_SQRT) ? CW'(WORD_WIDTH / 2) : CW'(WORD_WIDTH);
			end else if (busy_q) begin
				case (cmd_q)
					rau_pkg::ALU_MUL: begin
						if (opb_q[0])
							acc_q <= acc_q + opa_q;
						opa_q <= opa_q << 1;
						opb_q <= opb_q >> 1;
					end
					rau_pkg::ALU_DIV: begin
						opa_q <= opa_q << 1;
						if (trial >= {1'b0, opb_q}) begin
							rem_q <= WORD_WIDTH'(trial - {1'b0, opb_q});
							acc_q <= {acc_q[WORD_WIDTH-2:0], 1'b1};
						end else begin
							rem_q <= trial[WORD_WIDTH-1:0];
							acc_q <= {acc_q[WORD_WIDTH-2:0], 1'b0};
						end
					end
					default: begin
						opa_q <= opa_q << 2;
						if (sq_rem >= sq_try) begin
							rem_q <= WORD_WIDTH'(sq_rem - sq_try);
							acc_q <= {acc_q[WORD_WIDTH-2:0], 1'b1};
						end else begin
							rem_q <= sq_rem[WORD_WIDTH-1:0];
							acc_q <= {acc_q[WORD_WIDTH-2:0], 1'b0};
						end
					end
				endcase
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign res = acc_q;
	assign rem = rem_q;
endmodule

// File: sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit sequencer
// Steps one operation through the shared unit: cross products, combine,
// normalization with Euclid GCD, division by the GCD, or square roots.
// ----------------------------------------------------------------------------
module rau_ctrl #(
	parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            op,
	input  logic                  xn,
	input  logic [WORD_WIDTH-1:0] xu,
	input  logic [WORD_WIDTH-1:0] xd,
	input  logic                  yn,
	input  logic [WORD_WIDTH-1:0] yu,
	input  logic [WORD_WIDTH-1:0] yd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  r_neg,
	output logic [WORD_WIDTH-1:0] r_num,
	output logic [WORD_WIDTH-1:0] r_den,
	output logic [1:0]            r_ord,
	output logic                  r_err,
	output logic                  busy
);
	rau_pkg::state_t state_q, state_d;
	logic [2:0]            op_q;
	logic                  xn_q, yn_q, neg_q, err_q;
	logic [WORD_WIDTH-1:0] xu_q, xd_q, yu_q, yd_q;
	logic [WORD_WIDTH-1:0] v1_q, v2_q, num_q, den_q, ga_q, gb_q;
	logic [1:0]            ord_q;

	logic                  a_start, a_done;
	rau_pkg::alu_cmd_t     a_cmd;
	logic [WORD_WIDTH-1:0] a_a, a_b, a_res, a_rem;

	rau_alu #(.WORD_WIDTH(WORD_WIDTH)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(a_start), .cmd(a_cmd),
		.a(a_a), .b(a_b), .done(a_done), .res(a_res), .rem(a_rem)
	);

	logic eff_yn;
	assign eff_yn = (op_q == rau_pkg::OP_SUB) ? !yn_q : yn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rau_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		a_start = 1'b0;
		a_cmd   = rau_pkg::ALU_MUL;
		a_a     = '0;
		a_b     = '0;
		case (state_q)
			rau_pkg::ST_IDLE: if (in_valid) state_d = rau_pkg::ST_M1;
			rau_pkg::ST_M1: begin
				a_start = 1'b1;
				if (op_q == rau_pkg::OP_MUL) begin
					a_a = xu_q; a_b = yu_q;
				end else begin
					a_a = xu_q; a_b = yd_q;
				end
				case (op_q)
					rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL:
						state_d = rau_pkg::ST_M1W;
					rau_pkg::OP_DIV:
						state_d = (yu_q == '0) ? rau_pkg::ST_OUT : rau_pkg::ST_M1W;
					rau_pkg::OP_CMP:
						state_d = ((xu_q == '0 && yu_q == '0) || xn_q != yn_q) ?
							rau_pkg::ST_OUT : rau_pkg::ST_M1W;
					rau_pkg::OP_SQRT:
						state_d = (xu_q == '0) ? rau_pkg::ST_OUT : rau_pkg::ST_SQ1;
					default: state_d = rau_pkg::ST_OUT;
				endcase
				if (state_d != rau_pkg::ST_M1W) a_start = 1'b0;
			end
			rau_pkg::ST_M1W: if (a_done) state_d = rau_pkg::ST_M2;
			rau_pkg::ST_M2: begin
				a_start = 1'b1;
				if (op_q == rau_pkg::OP_MUL) begin
					a_a = xd_q; a_b = yd_q;
				end else begin
					a_a = xd_q; a_b = yu_q;
				end
				state_d = rau_pkg::ST_M2W;
			end
			rau_pkg::ST_M2W: if (a_done)
				state_d = (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) ?
					rau_pkg::ST_M3 : rau_pkg::ST_COMB;
			rau_pkg::ST_M3: begin
				a_start = 1'b1; a_a = xd_q; a_b = yd_q;
				state_d = rau_pkg::ST_M3W;
			end
			rau_pkg::ST_M3W: if (a_done) state_d = rau_pkg::ST_COMB;
			rau_pkg::ST_COMB:
				state_d = (op_q == rau_pkg::OP_CMP) ? rau_pkg::ST_OUT : rau_pkg::ST_NORM;
			rau_pkg::ST_NORM: begin
				if (den_q == '0 || num_q == '0 || num_q == den_q ||
						num_q == WORD_WIDTH'(1) || den_q == WORD_WIDTH'(1))
					state_d = rau_pkg::ST_OUT;
				else
					state_d = rau_pkg::ST_GCD;
			end
			rau_pkg::ST_GCD: begin
				if (gb_q == '0)
					state_d = rau_pkg::ST_DN;
				else begin
					a_start = 1'b1; a_cmd = rau_pkg::ALU_DIV; a_a = ga_q; a_b = gb_q;
					state_d = rau_pkg::ST_GCDW;
				end
			end
			rau_pkg::ST_GCDW: if (a_done) state_d = rau_pkg::ST_GCD;
			rau_pkg::ST_DN: begin
				a_start = 1'b1; a_cmd = rau_pkg::ALU_DIV; a_a = num_q; a_b = ga_q;
				state_d = rau_pkg::ST_DNW;
			end
			rau_pkg::ST_DNW: if (a_done) state_d = rau_pkg::ST_DD;
			rau_pkg::ST_DD: begin
				a_start = 1'b1; a_cmd = rau_pkg::ALU_DIV; a_a = den_q; a_b = ga_q;
				state_d = rau_pkg::ST_DDW;
			end
			rau_pkg::ST_DDW: if (a_done) state_d = rau_pkg::ST_OUT;
			rau_pkg::ST_SQ1: begin
				a_start = 1'b1; a_cmd = rau_pkg::ALU_SQRT; a_a = xu_q;
				state_d = rau_pkg::ST_SQ1W;
			end
			rau_pkg::ST_SQ1W: if (a_done) state_d = rau_pkg::ST_SQ2;
			rau_pkg::ST_SQ2: begin
				a_start = 1'b1; a_cmd = rau_pkg::ALU_SQRT; a_a = xd_q;
				state_d = rau_pkg::ST_SQ2W;
			end
			rau_pkg::ST_SQ2W: if (a_done) state_d = rau_pkg::ST_OUT;
			rau_pkg::ST_OUT: if (out_ready) state_d = rau_pkg::ST_IDLE;
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: if (in_valid) begin
				op_q <= op; xn_q <= xn; xu_q <= xu; xd_q <= xd;
				yn_q <= yn; yu_q <= yu; yd_q <= yd;
				neg_q <= xn; num_q <= xu; den_q <= xd;
				ord_q <= 2'b00;
				err_q <= !(op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB ||
					op == rau_pkg::OP_MUL || op == rau_pkg::OP_DIV ||
					op == rau_pkg::OP_CMP || op == rau_pkg::OP_SQRT);
			end
			rau_pkg::ST_M1: begin
				if (op_q == rau_pkg::OP_DIV && yu_q == '0) err_q <= 1'b1;
				if (op_q == rau_pkg::OP_CMP && !(xu_q == '0 && yu_q == '0) && xn_q != yn_q)
					ord_q <= xn_q ? 2'b11 : 2'b01;
				if (op_q == rau_pkg::OP_SQRT && xu_q != '0 && xn_q) begin
					err_q <= 1'b1; neg_q <= 1'b0;
				end
			end
			rau_pkg::ST_M1W: if (a_done) v1_q <= a_res;
			rau_pkg::ST_M2W: if (a_done) v2_q <= a_res;
			rau_pkg::ST_M3W: if (a_done) den_q <= a_res;
			rau_pkg::ST_COMB: begin
				case (op_q)
					rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
						if (xn_q == eff_yn) begin
							num_q <= v1_q + v2_q; neg_q <= xn_q;
						end else if (v1_q >= v2_q) begin
							num_q <= v1_q - v2_q; neg_q <= xn_q;
						end else begin
							num_q <= v2_q - v1_q; neg_q <= eff_yn;
						end
					end
					rau_pkg::OP_CMP: begin
						if (v1_q == v2_q) ord_q <= 2'b00;
						else if (v1_q > v2_q) ord_q <= xn_q ? 2'b11 : 2'b01;
						else ord_q <= xn_q ? 2'b01 : 2'b11;
					end
					default: begin
						neg_q <= xn_q != yn_q; num_q <= v1_q; den_q <= v2_q;
					end
				endcase
			end
			rau_pkg::ST_NORM: begin
				ga_q <= num_q; gb_q <= den_q;
				if (den_q == '0) err_q <= 1'b1;
				else if (num_q == '0) begin
					den_q <= WORD_WIDTH'(1); neg_q <= 1'b0;
				end else if (num_q == den_q) begin
					num_q <= WORD_WIDTH'(1); den_q <= WORD_WIDTH'(1);
				end
			end
			rau_pkg::ST_GCDW: if (a_done) begin
				ga_q <= gb_q; gb_q <= a_rem;
			end
			rau_pkg::ST_DNW: if (a_done) num_q <= a_res;
			rau_pkg::ST_DDW: if (a_done) den_q <= a_res;
			rau_pkg::ST_SQ1W: if (a_done) num_q <= a_res;
			rau_pkg::ST_SQ2W: if (a_done) den_q <= a_res;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == rau_pkg::ST_IDLE);
	assign out_valid = (state_q == rau_pkg::ST_OUT);
	assign busy      = !in_ready;
	assign r_neg = neg_q;
	assign r_num = num_q;
	assign r_den = den_q;
	assign r_ord = ord_q;
	assign r_err = err_q;
endmodule
